FILE: rtl/core/nearest_pixel_search_core_macros.svh
// ---------------------------------------------------------------------------
// nearest_pixel_search_core_macros.svh
// Assertion helpers shared by the nearest pixel search RTL.
// ---------------------------------------------------------------------------
`ifndef NEAREST_PIXEL_SEARCH_CORE_MACROS_SVH
`define NEAREST_PIXEL_SEARCH_CORE_MACROS_SVH

// Condition must never be true outside reset
`define NPS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Whenever ante holds, cons must hold in the same cycle
`define NPS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/nps_pkg.sv
// ---------------------------------------------------------------------------
// nps_pkg
// Shared codes, types and defaults for the nearest pixel search core.
// ---------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_COORD_WIDTH = 16;

  // Request codes on the input tuser
  localparam int REQ_W = 2;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  // Result status codes on the output tuser
  localparam int STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OUT_WIN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_R_LO   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_R_HI   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PHI_LO = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PHI_HI = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_Z_LO   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_Z_HI   = 3'd5;

  // Result field widths and output packing
  localparam int INDEX_W  = 10;
  localparam int DIST_W   = 34;
  localparam int M_DATA_W = ((INDEX_W + DIST_W + 7) / 8) * 8;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Command kinds passed from front to back
  localparam int KIND_W = 2;
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD,
    KIND_QUERY,
    KIND_REJECT,
    KIND_CLEAR
  } cmd_kind_t;

  // One result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   best_dist_sq;
    logic [INDEX_W-1:0]  pixel_index;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/nps_ram.sv
// ---------------------------------------------------------------------------
// nps_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module nps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nps_front.sv
// ---------------------------------------------------------------------------
// nps_front
// Input side: holds the query windows, classifies each beat and queues all but unused requests.
// ---------------------------------------------------------------------------
`default_nettype none

module nps_front #(
  parameter int COORD_WIDTH = 16,
  parameter int S_DATA_W    = 48
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  // configuration writes
  input  wire logic                                     cfg_wr_en,
  input  wire logic [nps_pkg::CFG_ADDR_W-1:0]           cfg_addr,
  input  wire logic [COORD_WIDTH-1:0]                   cfg_wdata,
  // input stream
  input  wire logic                                     s_tvalid,
  output logic                                          s_tready,
  input  wire logic [S_DATA_W-1:0]                      s_tdata,
  input  wire logic [nps_pkg::REQ_W-1:0]                s_tuser,
  // command queue write side
  input  wire logic                                     fifo_full,
  output logic                                          push,
  output logic [nps_pkg::KIND_W+3*COORD_WIDTH-1:0]      push_data
);

  import nps_pkg::*;

  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = ~COORD_MIN;

  logic signed [COORD_WIDTH-1:0] r_lo, r_hi, phi_lo, phi_hi, z_lo, z_hi;
  logic signed [COORD_WIDTH-1:0] c_r, c_phi, c_z;
  logic                          in_win;
  cmd_kind_t                     kind;

  // Window registers; the user must write them only while the core is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      r_lo   <= COORD_MIN;
      r_hi   <= COORD_MAX;
      phi_lo <= COORD_MIN;
      phi_hi <= COORD_MAX;
      z_lo   <= COORD_MIN;
      z_hi   <= COORD_MAX;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_R_LO:   r_lo   <= cfg_wdata;
        CFG_R_HI:   r_hi   <= cfg_wdata;
        CFG_PHI_LO: phi_lo <= cfg_wdata;
        CFG_PHI_HI: phi_hi <= cfg_wdata;
        CFG_Z_LO:   z_lo   <= cfg_wdata;
        CFG_Z_HI:   z_hi   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Unpack coordinates
  assign c_r   = s_tdata[COORD_WIDTH-1:0];
  assign c_phi = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign c_z   = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

  // Inclusive window check on all three axes
  assign in_win = (c_r >= r_lo) && (c_r <= r_hi) &&
                  (c_phi >= phi_lo) && (c_phi <= phi_hi) &&
                  (c_z >= z_lo) && (c_z <= z_hi);

  // Classify the request
  always_comb begin
    unique case (s_tuser)
      REQ_LOAD:  kind = KIND_LOAD;
      REQ_QUERY: kind = in_win ? KIND_QUERY : KIND_REJECT;
      REQ_CLEAR: kind = KIND_CLEAR;
      default:   kind = KIND_LOAD;
    endcase
  end

  // Unused request codes are consumed without a queue entry
  assign s_tready  = !fifo_full;
  assign push      = s_tvalid && !fifo_full && (s_tuser != REQ_NONE);
  assign push_data = {kind, c_z, c_phi, c_r};

endmodule

`default_nettype wire

FILE: rtl/core/nps_fifo.sv
// ---------------------------------------------------------------------------
// nps_fifo
// Two-entry command queue between the front and back sections.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nearest_pixel_search_core_macros.svh"

module nps_fifo #(
  parameter int WIDTH = 50
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       used;

  assign full     = (used == 2'd2);
  assign empty    = (used == 2'd0);
  assign pop_data = entries[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   used <= used + 2'd1;
        2'b01:   used <= used - 2'd1;
        default: used <= used;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `NPS_ASSERT_NEVER(a_no_overflow, clk, rst, push && full, "command queue overflow")
  `NPS_ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty, "command queue underflow")
  `NPS_ASSERT_NEVER(a_used_range, clk, rst, used == 2'd3, "command queue count out of range")

endmodule

`default_nettype wire

FILE: rtl/core/nps_back.sv
// ---------------------------------------------------------------------------
// nps_back
// Execution side: pixel table, load/clear handling and the nearest scan.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nearest_pixel_search_core_macros.svh"

module nps_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  // command queue read side
  input  wire logic                                     cmd_valid,
  input  wire logic [nps_pkg::KIND_W+3*COORD_WIDTH-1:0] cmd_data,
  output logic                                          cmd_pop,
  // result register
  output logic                                          m_tvalid,
  input  wire logic                                     m_tready,
  output nps_pkg::result_t                              result
);

  import nps_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = AW + 1;
  localparam int SUM_W = 2 * COORD_WIDTH + 2;
  localparam int SAT_W = (SUM_W > 64) ? 64 : SUM_W;
  localparam int EXT_W = SAT_W + DIST_W;
  localparam int CW    = COORD_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  issue;
  logic [CW-1:0]     q_r, q_phi, q_z;

  // command fields
  cmd_kind_t         kind;
  logic [CW-1:0]     c_r, c_phi, c_z;

  // table RAM
  logic              ram_we;
  logic              rd_en;
  logic [3*CW-1:0]   rd_data;
  logic [CW-1:0]     t_r, t_phi, t_z;

  // distance pipeline
  logic              p1_valid, p2_valid, p3_valid, p4_valid;
  logic [AW-1:0]     p1_idx, p2_idx, p3_idx, p4_idx;
  logic [CW:0]       d_r, d_phi, d_z;
  logic [CW-1:0]     a_r, a_phi, a_z;
  logic [2*CW-1:0]   s_r, s_phi, s_z;
  logic [SUM_W-1:0]  sum_full;
  logic [SAT_W-1:0]  sum_sat;
  logic [SAT_W-1:0]  sum4;

  // running best
  logic [SAT_W-1:0]  best;
  logic [AW-1:0]     best_idx;
  logic              first;

  logic              out_valid;
  logic              out_set;
  logic              out_free;
  logic              has_room;
  logic              scan_done;
  logic [EXT_W-1:0]  best_ext;
  logic [DIST_W-1:0] dist_sat;
  logic [AW+INDEX_W-1:0]    best_idx_ext;
  logic [CNT_W+INDEX_W-1:0] cnt_ext;

  // Command unpack
  assign c_r   = cmd_data[CW-1:0];
  assign c_phi = cmd_data[2*CW-1:CW];
  assign c_z   = cmd_data[3*CW-1:2*CW];
  assign kind  = cmd_kind_t'(cmd_data[KIND_W+3*CW-1:3*CW]);

  // Handshake and control terms
  assign out_free  = !out_valid || m_tready;
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid && out_free;
  assign has_room  = (count < CNT_W'(TABLE_DEPTH));
  assign ram_we    = cmd_pop && (kind == KIND_LOAD) && has_room;
  assign rd_en     = (state == ST_SCAN) && (issue < count);
  assign scan_done = (state == ST_SCAN) && !rd_en &&
                     !p1_valid && !p2_valid && !p3_valid && !p4_valid;

  // A result beat is loaded on every popped command except a scanning query,
  // and when a scan finishes
  assign out_set = (cmd_pop && ((kind != KIND_QUERY) || (count == '0))) ||
                   ((state == ST_FINISH) && out_free);

  // Pixel table, one word holds {z, phi, r}
  nps_ram #(
    .WIDTH (3 * CW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({c_z, c_phi, c_r}),
    .re    (rd_en),
    .raddr (issue[AW-1:0]),
    .rdata (rd_data)
  );

  assign t_r   = rd_data[CW-1:0];
  assign t_phi = rd_data[2*CW-1:CW];
  assign t_z   = rd_data[3*CW-1:2*CW];

  // Axis differences; magnitude always fits CW bits
  assign d_r   = {q_r[CW-1], q_r} - {t_r[CW-1], t_r};
  assign d_phi = {q_phi[CW-1], q_phi} - {t_phi[CW-1], t_phi};
  assign d_z   = {q_z[CW-1], q_z} - {t_z[CW-1], t_z};

  // Sum of squares, clamped to 64 bits for wide coordinates
  assign sum_full = SUM_W'(s_r) + SUM_W'(s_phi) + SUM_W'(s_z);
  if (SUM_W > SAT_W) begin : g_sat
    assign sum_sat = (|sum_full[SUM_W-1:SAT_W]) ? '1 : sum_full[SAT_W-1:0];
  end else begin : g_nosat
    assign sum_sat = sum_full;
  end

  // Result formatting
  assign best_ext     = EXT_W'(best);
  assign dist_sat     = (best_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : best_ext[DIST_W-1:0];
  assign best_idx_ext = (AW + INDEX_W)'(best_idx);
  assign cnt_ext      = (CNT_W + INDEX_W)'(count);

  assign m_tvalid = out_valid;

  // Sequencer, scan pipeline and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      p4_valid  <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      // distance pipeline: read, abs diff, square, sum, compare
      p1_valid <= rd_en;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
      p1_idx   <= issue[AW-1:0];
      p2_idx   <= p1_idx;
      p3_idx   <= p2_idx;
      p4_idx   <= p3_idx;
      a_r      <= d_r[CW] ? CW'(-d_r) : d_r[CW-1:0];
      a_phi    <= d_phi[CW] ? CW'(-d_phi) : d_phi[CW-1:0];
      a_z      <= d_z[CW] ? CW'(-d_z) : d_z[CW-1:0];
      s_r      <= (2*CW)'(a_r) * (2*CW)'(a_r);
      s_phi    <= (2*CW)'(a_phi) * (2*CW)'(a_phi);
      s_z      <= (2*CW)'(a_z) * (2*CW)'(a_z);
      sum4     <= sum_sat;

      if (rd_en) begin
        issue <= issue + CNT_W'(1);
      end

      // strict less-than keeps the lowest index on ties
      if (p4_valid && (first || (sum4 < best))) begin
        best     <= sum4;
        best_idx <= p4_idx;
        first    <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            unique case (kind)
              KIND_LOAD: begin
                result.best_dist_sq <= '0;
                if (has_room) begin
                  count              <= count + CNT_W'(1);
                  result.status      <= ST_LOADED;
                  result.pixel_index <= cnt_ext[INDEX_W-1:0];
                end else begin
                  result.status      <= ST_FULL;
                  result.pixel_index <= '0;
                end
              end
              KIND_CLEAR: begin
                count               <= '0;
                result.status       <= ST_CLEARED;
                result.pixel_index  <= '0;
                result.best_dist_sq <= '0;
              end
              KIND_REJECT: begin
                result.status       <= ST_OUT_WIN;
                result.pixel_index  <= '0;
                result.best_dist_sq <= '0;
              end
              KIND_QUERY: begin
                if (count == '0) begin
                  result.status       <= ST_EMPTY;
                  result.pixel_index  <= '0;
                  result.best_dist_sq <= '0;
                end else begin
                  q_r   <= c_r;
                  q_phi <= c_phi;
                  q_z   <= c_z;
                  issue <= '0;
                  first <= 1'b1;
                  state <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            result.status       <= ST_FOUND;
            result.pixel_index  <= best_idx_ext[INDEX_W-1:0];
            result.best_dist_sq <= dist_sat;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `NPS_ASSERT_NEVER(a_issue_bound, clk, rst, (state == ST_SCAN) && (issue > count), "scan ran past table fill")
  `NPS_ASSERT_IMPLIES(a_best_in_table, clk, rst, (state == ST_FINISH), (CNT_W'(best_idx) < count), "nearest index outside table")
  `NPS_ASSERT_NEVER(a_no_ram_write_in_scan, clk, rst, ram_we && (state != ST_IDLE), "table written during scan")

endmodule

`default_nettype wire

FILE: rtl/core/nearest_pixel_search_core.sv
// ---------------------------------------------------------------------------
// nearest_pixel_search_core
// Pixel table with brute-force nearest search over (r, phi, z) positions.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake               Content
//  s_*      in   s_tvalid / s_tready     tuser: req_type; tdata: r, phi, z
//  m_*      out  m_tvalid / m_tready     tuser: status; tdata: index, dist
//  cfg_*    in   cfg_wr_en (no wait)     window registers r/phi/z lo/hi
//
//  Load, clear, rejected queries and queries on an empty table are answered
//  from the idle state of the back section. A query in the window scans the
//  table, reading the single read port once per stored pixel.
//  Reset is synchronous; it empties the table (count only) and restores
//  the windows to the full coordinate range. No clearing pass is needed.
//  A two-entry command queue lets input beats be taken while the back
//  section scans or while m_tready holds a finished result.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_pixel_search_core #(
  parameter int TABLE_DEPTH = nps_pkg::DEF_TABLE_DEPTH,
  parameter int COORD_WIDTH = nps_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration
  input  wire logic                                 cfg_wr_en,
  input  wire logic [nps_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire logic [COORD_WIDTH-1:0]               cfg_wdata,
  // input stream
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // tdata: coord_r, coord_phi, coord_z, zero pad
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
  // tuser: req_type
  input  wire logic [nps_pkg::REQ_W-1:0]            s_tuser,
  // result stream
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // tdata: pixel_index, best_dist_sq, zero pad
  output logic [nps_pkg::M_DATA_W-1:0]              m_tdata,
  // tuser: status
  output logic [nps_pkg::STATUS_W-1:0]              m_tuser
);

  import nps_pkg::*;

  localparam int S_DATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;
  localparam int CMD_W    = KIND_W + 3 * COORD_WIDTH;
  localparam int PAD_W    = M_DATA_W - INDEX_W - DIST_W;

  logic             fifo_full;
  logic             fifo_empty;
  logic             push;
  logic [CMD_W-1:0] push_data;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_data;
  result_t          result;

  // Front: windows and classification
  nps_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .S_DATA_W    (S_DATA_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  // Command queue
  nps_fifo #(
    .WIDTH (CMD_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_data),
    .empty     (fifo_empty)
  );

  // Back: table and scan
  nps_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!fifo_empty),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .result    (result)
  );

  // Output packing
  assign m_tdata = {{PAD_W{1'b0}}, result.best_dist_sq, result.pixel_index};
  assign m_tuser = result.status;

endmodule

`default_nettype wire

FILE: test/tb_nearest_pixel_search_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nearest_pixel_search_core
// Self-checking bench for the nearest pixel search core. A queue-fed driver
// sends load, query, clear and unused requests on the input stream. Each
// accepted beat runs through a local model of the pixel table and the three
// query windows, and the monitor checks every result beat against the oldest
// prediction. Window registers change only while the core is idle. Random
// stalls hit both streams, and the final segment runs at full rate.
// ---------------------------------------------------------------------------
module tb_nearest_pixel_search_core;
  import nps_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int COORD_W     = DEF_COORD_WIDTH;
  localparam int S_DATA_W    = ((3 * COORD_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DEEP_LOADS  = 220;
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef enum int {AX_R, AX_PHI, AX_Z} axis_t;

  typedef struct {
    logic [REQ_W-1:0]          kind;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] phi;
    logic signed [COORD_W-1:0] z;
  } pixel_req_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [COORD_W-1:0]    cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic [REQ_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  // Requests waiting for the driver, and results owed by the core
  pixel_req_t req_queue[$];
  result_t    search_results_due[$];
  int         reqs_queued = 0;
  int         beats_taken = 0;
  bit         failed = 1'b0;

  // 0: no stalls, 1: light, 2: heavy
  int stall_mode = 2;
  int send_gap = 0;
  int recv_gap = 0;

  // Local copy of the pixel table and the windows
  logic signed [COORD_W-1:0] pix_r   [TABLE_DEPTH];
  logic signed [COORD_W-1:0] pix_phi [TABLE_DEPTH];
  logic signed [COORD_W-1:0] pix_z   [TABLE_DEPTH];
  int                        pix_count = 0;
  logic signed [COORD_W-1:0] win_lo [3] = '{C_MIN, C_MIN, C_MIN};
  logic signed [COORD_W-1:0] win_hi [3] = '{C_MAX, C_MAX, C_MAX};

  // Table occupancy as the stimulus generator sees it
  int gen_count = 0;

  pixel_req_t                cur_req;
  result_t                   due_res;
  result_t                   got_res;
  result_t                   want_res;
  logic signed [COORD_W-1:0] last_r, last_phi, last_z;

  nearest_pixel_search_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // r, phi, z
    .s_tuser   (s_tuser),   // req_type
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // pixel_index, best_dist_sq, pad
    .m_tuser   (m_tuser)    // status
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Apply one request to the local table; returns 0 when no result is owed
  function automatic bit predict_search(input pixel_req_t rq, output result_t res);
    longint dr, dp, dz, d, best;
    int     best_i;
    res = '0;
    case (rq.kind)
      REQ_LOAD: begin
        if (pix_count < TABLE_DEPTH) begin
          pix_r[pix_count]   = rq.r;
          pix_phi[pix_count] = rq.phi;
          pix_z[pix_count]   = rq.z;
          res.status      = ST_LOADED;
          res.pixel_index = pix_count[INDEX_W-1:0];
          pix_count++;
        end else begin
          res.status = ST_FULL;
        end
      end
      REQ_QUERY: begin
        if (rq.r < win_lo[AX_R] || rq.r > win_hi[AX_R] ||
            rq.phi < win_lo[AX_PHI] || rq.phi > win_hi[AX_PHI] ||
            rq.z < win_lo[AX_Z] || rq.z > win_hi[AX_Z]) begin
          res.status = ST_OUT_WIN;
        end else if (pix_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          best   = 0;
          best_i = 0;
          // strict compare keeps the lowest index on ties
          for (int i = 0; i < pix_count; i++) begin
            dr = longint'(rq.r) - longint'(pix_r[i]);
            dp = longint'(rq.phi) - longint'(pix_phi[i]);
            dz = longint'(rq.z) - longint'(pix_z[i]);
            d  = dr * dr + dp * dp + dz * dz;
            if (i == 0 || d < best) begin
              best   = d;
              best_i = i;
            end
          end
          res.status       = ST_FOUND;
          res.pixel_index  = best_i[INDEX_W-1:0];
          res.best_dist_sq = best[DIST_W-1:0];
        end
      end
      REQ_CLEAR: begin
        pix_count  = 0;
        res.status = ST_CLEARED;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Driver: present queued requests, predict on every accepted beat
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        beats_taken++;
        if (predict_search(cur_req, due_res))
          search_results_due = {search_results_due, due_res};
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          cur_req = req_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_req.z, cur_req.phi, cur_req.r};
          s_tuser  <= cur_req.kind;
          // idle burst after this beat
          if (stall_mode != 0 &&
              $urandom_range(0, (stall_mode == 1) ? 15 : 3) == 0)
            send_gap = $urandom_range(1, 12);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check result beats in order, stall m_tready in bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_res.status       = m_tuser;
        got_res.pixel_index  = m_tdata[INDEX_W-1:0];
        got_res.best_dist_sq = m_tdata[INDEX_W +: DIST_W];
        if (search_results_due.size() == 0) begin
          $error("result beat with nothing pending: status %0d, pixel_index %0d",
                 got_res.status, got_res.pixel_index);
          failed = 1'b1;
        end else begin
          want_res = search_results_due.pop_front();
          if (got_res.status !== want_res.status) begin
            $error("status: expected %0d, actual %0d", want_res.status, got_res.status);
            failed = 1'b1;
          end
          if (got_res.pixel_index !== want_res.pixel_index) begin
            $error("pixel_index: expected %0d, actual %0d",
                   want_res.pixel_index, got_res.pixel_index);
            failed = 1'b1;
          end
          if (got_res.best_dist_sq !== want_res.best_dist_sq) begin
            $error("best_dist_sq: expected %0d, actual %0d",
                   want_res.best_dist_sq, got_res.best_dist_sq);
            failed = 1'b1;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if (stall_mode != 0 &&
                   $urandom_range(0, (stall_mode == 1) ? 15 : 4) == 0) begin
        recv_gap = $urandom_range(0, 11);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic queue_req(input logic [REQ_W-1:0] kind,
                           input logic signed [COORD_W-1:0] r, phi, z);
    pixel_req_t rq;
    rq = '{kind, r, phi, z};
    req_queue = {req_queue, rq};
    reqs_queued++;
    if (kind == REQ_CLEAR) gen_count = 0;
    if (kind == REQ_LOAD && gen_count < TABLE_DEPTH) gen_count++;
  endtask

  // Wait for every beat to be taken and answered, then let the back end settle
  task automatic wait_idle();
    do @(negedge clk);
    while (beats_taken != reqs_queued || search_results_due.size() != 0);
    repeat (32) @(negedge clk);
  endtask

  task automatic set_windows(input logic signed [COORD_W-1:0] rl, rh, pl, ph, zl, zh);
    logic [CFG_ADDR_W-1:0]     addr [6];
    logic signed [COORD_W-1:0] val  [6];
    addr = '{CFG_R_LO, CFG_R_HI, CFG_PHI_LO, CFG_PHI_HI, CFG_Z_LO, CFG_Z_HI};
    val  = '{rl, rh, pl, ph, zl, zh};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_addr  <= addr[i];
      cfg_wdata <= val[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_lo[AX_R]   = rl;
    win_hi[AX_R]   = rh;
    win_lo[AX_PHI] = pl;
    win_hi[AX_PHI] = ph;
    win_lo[AX_Z]   = zl;
    win_hi[AX_Z]   = zh;
    @(negedge clk);
  endtask

  // Full-range value, biased toward the extremes
  function automatic logic signed [COORD_W-1:0] rand_coord();
    logic [31:0] u;
    u = $urandom();
    case ($urandom_range(0, 9))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return '1;
      default: return u[COORD_W-1:0];
    endcase
  endfunction

  // Query coordinate: 1 inside the window, 2 on or just past an edge, else random
  function automatic logic signed [COORD_W-1:0] axis_coord(input axis_t ax, input int mode);
    int lo, hi;
    lo = win_lo[ax];
    hi = win_hi[ax];
    case (mode)
      1: begin
        if (lo <= hi) return COORD_W'(lo + $urandom_range(0, hi - lo));
        return rand_coord();
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       return COORD_W'(lo - 1);
          1:       return COORD_W'(lo);
          2:       return COORD_W'(hi);
          default: return COORD_W'(hi + 1);
        endcase
      end
      default: return rand_coord();
    endcase
  endfunction

  task automatic random_windows();
    logic signed [COORD_W-1:0] a [3];
    logic signed [COORD_W-1:0] b [3];
    logic signed [COORD_W-1:0] t;
    for (int ax = 0; ax < 3; ax++) begin
      a[ax] = rand_coord();
      b[ax] = rand_coord();
      if (a[ax] > b[ax]) begin
        t     = a[ax];
        a[ax] = b[ax];
        b[ax] = t;
      end
    end
    set_windows(a[AX_R], b[AX_R], a[AX_PHI], b[AX_PHI], a[AX_Z], b[AX_Z]);
  endtask

  // Mostly load batches followed by queries against them, some noise
  task automatic random_segment(input int n_items);
    int                        done, n_load, n_query, mode;
    logic [REQ_W-1:0]          kind;
    logic signed [COORD_W-1:0] qr, qp, qz;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        if (gen_count > 96 || $urandom_range(0, 1) == 1) begin
          queue_req(REQ_CLEAR, rand_coord(), rand_coord(), rand_coord());
          done++;
        end
        n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        for (int i = 0; i < n_load; i++) begin
          // repeated pixels make distance ties
          if (i == 0 || $urandom_range(0, 5) != 0) begin
            last_r   = rand_coord();
            last_phi = rand_coord();
            last_z   = rand_coord();
          end
          queue_req(REQ_LOAD, last_r, last_phi, last_z);
          done++;
        end
        n_query = $urandom_range(1, 6);
        for (int i = 0; i < n_query; i++) begin
          mode = $urandom_range(0, 3);
          if (mode == 0) begin
            qr = last_r;
            qp = last_phi;
            qz = last_z;
            if ($urandom_range(0, 1) == 1) begin
              qr = COORD_W'(qr + $urandom_range(0, 6) - 3);
              qp = COORD_W'(qp + $urandom_range(0, 6) - 3);
              qz = COORD_W'(qz + $urandom_range(0, 6) - 3);
            end
          end else begin
            qr = axis_coord(AX_R, mode);
            qp = axis_coord(AX_PHI, mode);
            qz = axis_coord(AX_Z, mode);
          end
          queue_req(REQ_QUERY, qr, qp, qz);
          done++;
        end
      end else begin
        kind = REQ_W'($urandom_range(0, 3));
        queue_req(kind, rand_coord(), rand_coord(), rand_coord());
        if (kind != REQ_NONE) done++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset windows, empty table, extremes and ties
    stall_mode = 2;
    queue_req(REQ_QUERY, 16'sd0, 16'sd0, 16'sd0);
    queue_req(REQ_NONE, rand_coord(), rand_coord(), rand_coord());
    queue_req(REQ_CLEAR, 16'sd0, 16'sd0, 16'sd0);
    queue_req(REQ_LOAD, C_MIN, C_MIN, C_MIN);
    queue_req(REQ_LOAD, C_MAX, C_MAX, C_MAX);
    queue_req(REQ_LOAD, 16'sd0, 16'sd0, 16'sd0);
    queue_req(REQ_LOAD, 16'sd0, 16'sd0, 16'sd0);
    queue_req(REQ_LOAD, 16'sd100, -16'sd200, 16'sd300);
    queue_req(REQ_QUERY, 16'sd0, 16'sd0, 16'sd0);
    queue_req(REQ_QUERY, C_MAX, C_MAX, C_MAX);
    queue_req(REQ_QUERY, C_MIN, C_MAX, C_MIN);
    queue_req(REQ_QUERY, 16'sd99, -16'sd199, 16'sd301);
    queue_req(REQ_NONE, C_MAX, C_MIN, C_MAX);
    queue_req(REQ_QUERY, -16'sd1, -16'sd1, -16'sd1);
    queue_req(REQ_CLEAR, C_MAX, C_MAX, C_MAX);
    queue_req(REQ_QUERY, 16'sd5, 16'sd5, 16'sd5);
    queue_req(REQ_LOAD, 16'sd7, -16'sd7, 16'sd7);
    queue_req(REQ_QUERY, C_MIN, C_MIN, C_MIN);
    wait_idle();

    // Narrow windows: one-point phi window, z pinned at the bottom
    set_windows(-16'sd100, 16'sd100, 16'sd0, 16'sd0, C_MIN, C_MIN + 16'sd1);
    queue_req(REQ_QUERY, 16'sd0, 16'sd0, C_MIN);
    queue_req(REQ_QUERY, 16'sd101, 16'sd0, C_MIN);
    queue_req(REQ_QUERY, 16'sd0, 16'sd1, C_MIN);
    queue_req(REQ_QUERY, 16'sd0, 16'sd0, C_MIN + 16'sd2);
    queue_req(REQ_CLEAR, 16'sd0, 16'sd0, 16'sd0);
    // window check comes before the empty-table check
    queue_req(REQ_QUERY, 16'sd200, 16'sd0, 16'sd0);
    wait_idle();

    // Inverted r window rejects every query
    set_windows(16'sd5, 16'sd4, C_MIN, C_MAX, C_MIN, C_MAX);
    queue_req(REQ_LOAD, 16'sd4, 16'sd0, 16'sd0);
    queue_req(REQ_QUERY, 16'sd4, 16'sd0, 16'sd0);
    queue_req(REQ_QUERY, 16'sd5, 16'sd0, 16'sd0);
    wait_idle();

    // Deep table: long scans, query the last entry loaded
    set_windows(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    stall_mode = 1;
    queue_req(REQ_CLEAR, 16'sd0, 16'sd0, 16'sd0);
    for (int i = 0; i < DEEP_LOADS; i++) begin
      last_r   = rand_coord();
      last_phi = rand_coord();
      last_z   = rand_coord();
      queue_req(REQ_LOAD, last_r, last_phi, last_z);
    end
    queue_req(REQ_QUERY, last_r, last_phi, last_z);
    queue_req(REQ_QUERY, rand_coord(), rand_coord(), rand_coord());
    queue_req(REQ_QUERY, rand_coord(), rand_coord(), rand_coord());
    queue_req(REQ_CLEAR, 16'sd0, 16'sd0, 16'sd0);
    queue_req(REQ_QUERY, 16'sd0, 16'sd0, 16'sd0);
    wait_idle();

    // Random traffic under several window settings
    stall_mode = 2;
    random_segment(60);
    wait_idle();

    random_windows();
    stall_mode = 1;
    random_segment(60);
    wait_idle();

    set_windows(-16'sd2000, 16'sd2000, -16'sd2000, 16'sd2000, -16'sd2000, 16'sd2000);
    stall_mode = 2;
    random_segment(30);
    // hold the sender until the core has answered everything
    wait_idle();
    random_segment(30);
    wait_idle();

    set_windows(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX);
    stall_mode = 1;
    random_segment(30);
    wait_idle();

    // Closing stretch at full rate
    set_windows(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    stall_mode = 0;
    random_segment(60);
    wait_idle();
    repeat (64) @(negedge clk);

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: nearest_pixel_search_core.f
+incdir+rtl/core
rtl/core/nps_pkg.sv
rtl/core/nps_ram.sv
rtl/core/nps_front.sv
rtl/core/nps_fifo.sv
rtl/core/nps_back.sv
rtl/core/nearest_pixel_search_core.sv
test/tb_nearest_pixel_search_core.sv
